>>> rtl/core/mcs51dm_pkg.sv
package mcs51dm_pkg;

  typedef enum logic [1:0] {
    OP_BYTE_RD = 2'd0,
    OP_BYTE_WR = 2'd1,
    OP_BIT_RD  = 2'd2,
    OP_BIT_WR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] addr;
    logic [7:0] wdata;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       bit_value;
    logic       mapped;
  } out_beat_t;

  localparam int unsigned SFR_COUNT = 21;
  localparam int unsigned SfrIdxW   = 5;

  localparam logic [7:0] BIT_RAM_BASE  = 8'h20;
  localparam logic [7:0] BIT_SFR_MASK  = 8'hF8;
  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

  typedef struct packed {
    logic               hit;
    logic [SfrIdxW-1:0] idx;
  } sfr_sel_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } sfr_wr_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] rdata;
  } sfr_rsp_t;

  function automatic sfr_sel_t sfr_lookup(logic [7:0] a);
    sfr_sel_t s;
    s.hit = 1'b1;
    s.idx = '0;
    unique case (a)
      8'h80: s.idx = 5'd0;   // P0
      8'h81: s.idx = 5'd1;   // SP
      8'h82: s.idx = 5'd2;   // DPL
      8'h83: s.idx = 5'd3;   // DPH
      8'h87: s.idx = 5'd4;   // PCON
      8'h88: s.idx = 5'd5;   // TCON
      8'h89: s.idx = 5'd6;   // TMOD
      8'h8A: s.idx = 5'd7;   // TL0
      8'h8B: s.idx = 5'd8;   // TL1
      8'h8C: s.idx = 5'd9;   // TH0
      8'h8D: s.idx = 5'd10;  // TH1
      8'h90: s.idx = 5'd11;  // P1
      8'h98: s.idx = 5'd12;  // SCON
      8'h99: s.idx = 5'd13;  // SBUF
      8'hA0: s.idx = 5'd14;  // P2
      8'hA8: s.idx = 5'd15;  // IE
      8'hB0: s.idx = 5'd16;  // P3
      8'hB8: s.idx = 5'd17;  // IP
      8'hD0: s.idx = 5'd18;  // PSW
      8'hE0: s.idx = 5'd19;  // ACC
      8'hF0: s.idx = 5'd20;  // B
      default: s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/mcs51dm_sfr_file.sv
module mcs51dm_sfr_file (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           addr,
  input  mcs51dm_pkg::sfr_wr_t wr,
  output mcs51dm_pkg::sfr_rsp_t rsp
);

  logic [7:0] regs_r [mcs51dm_pkg::SFR_COUNT];
  mcs51dm_pkg::sfr_sel_t sel;

  assign sel = mcs51dm_pkg::sfr_lookup(addr);

  always_comb begin
    rsp.hit   = sel.hit;
    rsp.rdata = sel.hit ? regs_r[sel.idx] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(mcs51dm_pkg::SFR_COUNT); i++) begin
        regs_r[i] <= 8'h00;
      end
    end else if (wr.en && sel.hit) begin
      regs_r[sel.idx] <= wr.data;
    end
  end

endmodule

>>> rtl/core/mcs51_data_memory_bit_access_core.sv
// channel   ports                          beat
// input     in_valid / in_stall / in_data   op, addr, wdata
// result    out_valid / out_stall / out_data rdata, bit_value, mapped
//
// one beat per cycle sustained while out_stall is low; each beat passes the registered
// read port of the general ram and the decode stage registers, then the result register
// bit writes are read-modify-write; back-to-back hits on one ram byte are forwarded
// reset clears the special registers and the pipeline; general ram is not cleared
// out_stall holds the result register and the decode stage; in_stall rises only
// when both are full
module mcs51_data_memory_bit_access_core #(
  parameter int unsigned GENERAL_BYTES = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mcs51dm_pkg::in_beat_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mcs51dm_pkg::out_beat_t out_data
);

  localparam int unsigned RamAw    = $clog2(GENERAL_BYTES);
  localparam logic [8:0]  RamLimit = 9'(GENERAL_BYTES);

  // input stage decode: byte that the access touches
  logic [7:0] in_byte;
  logic       accept;

  always_comb begin
    if (in_data.op == mcs51dm_pkg::OP_BIT_RD || in_data.op == mcs51dm_pkg::OP_BIT_WR) begin
      if (in_data.addr[7]) begin
        in_byte = in_data.addr & mcs51dm_pkg::BIT_SFR_MASK;
      end else begin
        in_byte = mcs51dm_pkg::BIT_RAM_BASE + {3'b000, in_data.addr[7:3]};
      end
    end else begin
      in_byte = in_data.addr;
    end
  end

  // stage 1 registers
  logic                  s1_valid_r, s1_valid_nxt;
  mcs51dm_pkg::in_beat_t s1_beat_r;
  logic [7:0]            s1_byte_r;
  logic                  s1_go;

  logic [7:0] ram_mem [GENERAL_BYTES];
  logic [7:0] ram_q_r;

  logic             ram_we;
  logic [RamAw-1:0] ram_widx;
  logic [7:0]       ram_wdata;

  logic             wb_valid_r;
  logic [RamAw-1:0] wb_idx_r;
  logic [7:0]       wb_data_r;

  logic                   out_valid_r;
  mcs51dm_pkg::out_beat_t out_data_r, result;

  assign s1_go    = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_beat_r <= in_data;
      s1_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_widx] <= ram_wdata;
    end
    if (accept) begin
      ram_q_r <= ram_mem[in_byte[RamAw-1:0]];
    end
  end

  // stage 1 evaluate
  mcs51dm_pkg::sfr_wr_t  sfr_wr;
  mcs51dm_pkg::sfr_rsp_t sfr_rsp;

  mcs51dm_sfr_file u_sfr (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (s1_byte_r),
    .wr    (sfr_wr),
    .rsp   (sfr_rsp)
  );

  logic             ram_hit;
  logic [RamAw-1:0] s1_idx;
  logic [7:0]       ram_val, cur_byte, bit_mask, new_byte;
  logic             bit_ok, do_write, fire;
  logic [7:0]       wr_byte;

  assign s1_idx  = s1_byte_r[RamAw-1:0];
  assign ram_hit = ({1'b0, s1_byte_r} < RamLimit);
  assign fire    = s1_valid_r && s1_go;

  always_comb begin
    // last ram write lands the same edge the next beat reads ram
    ram_val  = (wb_valid_r && wb_idx_r == s1_idx) ? wb_data_r : ram_q_r;
    cur_byte = sfr_rsp.hit ? sfr_rsp.rdata
             : (ram_hit ? ram_val : mcs51dm_pkg::UNMAPPED_BYTE);
    bit_ok   = !s1_beat_r.addr[7] || sfr_rsp.hit;
    bit_mask = 8'b0000_0001 << s1_beat_r.addr[2:0];
    new_byte = s1_beat_r.wdata[0] ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);

    result   = '0;
    do_write = 1'b0;
    wr_byte  = s1_beat_r.wdata;
    unique case (s1_beat_r.op)
      mcs51dm_pkg::OP_BYTE_RD: begin
        result.rdata  = cur_byte;
        result.mapped = sfr_rsp.hit || ram_hit;
      end
      mcs51dm_pkg::OP_BYTE_WR: begin
        result.mapped = sfr_rsp.hit || ram_hit;
        do_write      = 1'b1;
      end
      mcs51dm_pkg::OP_BIT_RD: begin
        result.bit_value = bit_ok ? cur_byte[s1_beat_r.addr[2:0]] : 1'b1;
        result.mapped    = bit_ok;
      end
      mcs51dm_pkg::OP_BIT_WR: begin
        result.mapped = bit_ok;
        do_write      = bit_ok;
        wr_byte       = new_byte;
      end
      default: begin
        result = '0;
      end
    endcase

    sfr_wr.en   = fire && do_write && sfr_rsp.hit;
    sfr_wr.data = wr_byte;
    ram_we      = fire && do_write && !sfr_rsp.hit && ram_hit;
    ram_widx    = s1_idx;
    ram_wdata   = wr_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (ram_we) begin
      wb_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      wb_idx_r  <= ram_widx;
      wb_data_r <= ram_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fire_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("decode stage advanced without filling the result register");

  a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline had room");

  a_one_target : assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && sfr_wr.en))
    else $error("ram and special register written by one beat");

  a_write_needs_beat : assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we || sfr_wr.en) |-> (s1_valid_r && s1_go))
    else $error("storage written without a beat leaving decode");

endmodule
